// ===== rtl/lbd_pkg.sv =====
// ----------------------------------------------------------------------------
// lbd_pkg: list-mode buffer deframer shared types
// Record kinds, queue entry layout and stream signature constants.
// ----------------------------------------------------------------------------
`default_nettype none

package lbd_pkg;

  typedef enum logic {
    KIND_STAMP = 1'b0,
    KIND_EVENT = 1'b1
  } lbd_kind_t;

  // record waiting between front and back, raw bytes in arrival order
  typedef struct packed {
    lbd_kind_t   kind;
    logic [47:0] raw;
  } lbd_entry_t;

  localparam logic [63:0] HEADER_SIGNATURE = 64'h0000_5555_AAAA_FFFF;
  localparam logic [63:0] BUFFER_SEPARATOR = 64'h0000_FFFF_5555_AAAA;
  localparam logic [15:0] CLOSING_LENGTH   = 16'hFFFF;
  localparam int          SIG_MIN_POS      = 7;
  localparam int          STAMP_LAST_BYTE  = 17;
  localparam int          FIRST_EVENT_BYTE = 42;
  localparam int          EVENT_BYTES      = 6;

endpackage

`default_nettype wire

// ===== rtl/lbd_if.sv =====
// ----------------------------------------------------------------------------
// lbd_if: stream channels of the deframer
// Byte input channel and record output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface lbd_rec_if;
  logic        valid;
  logic        ready;
  logic        record_kind;
  logic [47:0] record_value;

  modport source (output valid, output record_kind, output record_value, input ready);
  modport sink (input valid, input record_kind, input record_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/lbd_front.sv =====
// ----------------------------------------------------------------------------
// lbd_front: byte parser
// Tracks header and separator signatures, buffer position and length, and
// pushes timestamp and event records into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lbd_front #(
  parameter int MAX_BUFFER_BYTES = 2048
) (
  input  wire                logic clk,
  input  wire                logic rst,
  lbd_byte_if.sink                 byte_in,
  input  wire                logic q_full,
  output                     logic push,
  output lbd_pkg::lbd_entry_t      push_entry
);

  localparam int PosW = $clog2(MAX_BUFFER_BYTES);
  localparam logic [PosW-1:0] POS_LAST  = PosW'(MAX_BUFFER_BYTES - 1);
  localparam logic [PosW-1:0] POS_SIG   = PosW'(lbd_pkg::SIG_MIN_POS);
  localparam logic [PosW-1:0] POS_STAMP = PosW'(lbd_pkg::STAMP_LAST_BYTE);
  localparam logic [PosW-1:0] POS_EVT0  = PosW'(lbd_pkg::FIRST_EVENT_BYTE);
  localparam logic [PosW-1:0] POS_EVT1  =
    PosW'(lbd_pkg::FIRST_EVENT_BYTE + lbd_pkg::EVENT_BYTES - 1);
  localparam logic [2:0]      PHASE_LAST = 3'(lbd_pkg::EVENT_BYTES - 1);

  logic [55:0]     window, window_next;
  logic            in_header, in_header_next;
  logic [PosW-1:0] pos, pos_next;
  logic [15:0]     word_length, word_length_next;
  logic [39:0]     assembly, assembly_next;
  logic [2:0]      phase, phase_next;

  logic            accept;
  logic [63:0]     full_word;
  logic [47:0]     raw;
  logic            enough;
  logic            live;
  logic [PosW-1:0] adv_pos;
  logic [2:0]      adv_phase;
  logic            in_length;

  assign byte_in.ready = !q_full;
  assign accept        = byte_in.valid && byte_in.ready;
  assign full_word     = {window, byte_in.data_byte};
  assign raw           = {assembly, byte_in.data_byte};
  assign enough        = pos >= POS_SIG;
  assign live          = pos != POS_LAST;
  assign in_length     = ({1'b0, 16'(pos)} + 17'd1) <= {word_length, 1'b0};

  // saturating position and wrapping event byte phase
  always_comb begin
    adv_pos   = pos;
    adv_phase = phase;
    if (live) begin
      adv_pos = pos + PosW'(1);
      if (pos >= POS_EVT0) begin
        adv_phase = (phase == PHASE_LAST) ? 3'd0 : phase + 3'd1;
      end
    end
  end

  always_comb begin
    window_next      = window;
    in_header_next   = in_header;
    pos_next         = pos;
    word_length_next = word_length;
    assembly_next    = assembly;
    phase_next       = phase;
    push             = 1'b0;
    push_entry.kind  = lbd_pkg::KIND_STAMP;
    push_entry.raw   = raw;
    if (accept) begin
      window_next   = full_word[55:0];
      assembly_next = raw[39:0];
      pos_next      = adv_pos;
      phase_next    = adv_phase;
      if (in_header) begin
        if (enough && full_word == lbd_pkg::HEADER_SIGNATURE) begin
          in_header_next = 1'b0;
          pos_next       = '0;
          window_next    = '0;
          phase_next     = 3'd0;
        end
      end else begin
        if (live) begin
          if (pos == '0) begin
            word_length_next = {byte_in.data_byte, 8'h00};
          end else if (pos == PosW'(1)) begin
            word_length_next = {word_length[15:8], byte_in.data_byte};
          end else if (word_length != lbd_pkg::CLOSING_LENGTH) begin
            if (pos == POS_STAMP) begin
              push            = 1'b1;
              push_entry.kind = lbd_pkg::KIND_STAMP;
            end else if (pos >= POS_EVT1 && phase == PHASE_LAST && in_length) begin
              push            = 1'b1;
              push_entry.kind = lbd_pkg::KIND_EVENT;
            end
          end
        end
        if (enough && full_word == lbd_pkg::BUFFER_SEPARATOR) begin
          pos_next    = '0;
          window_next = '0;
          phase_next  = 3'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window      <= '0;
      in_header   <= 1'b1;
      pos         <= '0;
      word_length <= '0;
      assembly    <= '0;
      phase       <= 3'd0;
    end else begin
      window      <= window_next;
      in_header   <= in_header_next;
      pos         <= pos_next;
      word_length <= word_length_next;
      assembly    <= assembly_next;
      phase       <= phase_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lbd_queue.sv =====
// ----------------------------------------------------------------------------
// lbd_queue: two-entry record queue
// Decouples the byte parser from the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lbd_queue (
  input  wire                 logic clk,
  input  wire                 logic rst,
  input  wire                 logic push,
  input  wire lbd_pkg::lbd_entry_t  push_entry,
  output                      logic full,
  input  wire                 logic pop,
  output                      logic rd_valid,
  output lbd_pkg::lbd_entry_t       rd_entry
);

  lbd_pkg::lbd_entry_t entries [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count, count_next;

  assign full     = count == 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_entry = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> rd_valid) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && count == 2'd1) |=> full) else $error("queue fill lost");
`endif

endmodule

`default_nettype wire

// ===== rtl/lbd_back.sv =====
// ----------------------------------------------------------------------------
// lbd_back: record output stage
// Pops queued records, reorders words and holds the result for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module lbd_back (
  input  wire                 logic clk,
  input  wire                 logic rst,
  input  wire                 logic rd_valid,
  input  wire lbd_pkg::lbd_entry_t  rd_entry,
  output                      logic pop,
  lbd_rec_if.source                 rec_out
);

  logic        valid;
  logic        kind;
  logic [47:0] value;

  // first word to low, last word to high
  function automatic logic [47:0] word_order(input logic [47:0] raw);
    return {raw[15:0], raw[31:16], raw[47:32]};
  endfunction

  assign pop                  = rd_valid && (!valid || rec_out.ready);
  assign rec_out.valid        = valid;
  assign rec_out.record_kind  = kind;
  assign rec_out.record_value = value;

  always_ff @(posedge clk) begin
    if (pop) begin
      kind  <= logic'(rd_entry.kind);
      value <= word_order(rd_entry.raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (pop) begin
      valid <= 1'b1;
    end else if (rec_out.ready) begin
      valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/listmode_buffer_deframer_core.sv =====
// ----------------------------------------------------------------------------
// listmode_buffer_deframer_core: list-mode buffer deframer
// byte_in takes one stream byte per beat. rec_out gives one record per beat:
// record_kind 0 is a buffer timestamp, 1 an event word, record_value the
// 48-bit value with the first word in the low bits.
// Header bytes are skipped until the header signature, then buffers are
// cut at each separator. Every buffer but a closing one (length FFFF)
// yields its timestamp and its events, an event leaving as soon as its
// sixth byte is in. Throughput: one byte per cycle while the queue is not
// full; the parser updates all its state in the cycle a byte is taken. A
// record reaches rec_out through the queue entry and the output register.
// When the receiver stalls, the output register holds its record and the
// two-entry queue fills; byte_in.ready drops only when the queue is full.
// Reset (rst, synchronous) returns to header mode with empty queue and
// clears position, length and byte history.
// ----------------------------------------------------------------------------
`default_nettype none

module listmode_buffer_deframer_core #(
  parameter int MAX_BUFFER_BYTES = 2048
) (
  input wire logic  clk,
  input wire logic  rst,
  lbd_byte_if.sink  byte_in,
  lbd_rec_if.source rec_out
);

  logic                push;
  lbd_pkg::lbd_entry_t push_entry;
  logic                q_full;
  logic                pop;
  logic                rd_valid;
  lbd_pkg::lbd_entry_t rd_entry;

  lbd_front #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_in),
    .q_full    (q_full),
    .push      (push),
    .push_entry(push_entry)
  );

  lbd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (pop),
    .rd_valid  (rd_valid),
    .rd_entry  (rd_entry)
  );

  lbd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .rd_valid(rd_valid),
    .rd_entry(rd_entry),
    .pop     (pop),
    .rec_out (rec_out)
  );

endmodule

`default_nettype wire
